// ----- rtl/core/arpc_pkg.sv -----
// Shared constants, opcodes and controller/datapath link types for the ARP cache.
`timescale 1ns / 1ps

package arpc_pkg;

	// Table geometry.
	localparam int ENTRIES = 10;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Field widths.
	localparam int IP_W = 32;
	localparam int MAC_W = 48;
	localparam int AGE_W = 7;

	// Ages stop counting at the top of their range.
	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	// All-ones broadcast MAC returned on a miss.
	localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

	// An empty row holds address zero.
	localparam logic [IP_W-1:0] EMPTY_ADDR = '0;

	// Item opcodes.
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_REMEMBER = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the accepted item and restart the scan
		logic idx_inc;    // step the scan index to the next row
		logic age_all;    // age every row by one
		logic lk_hit;     // lookup matched the current row
		logic track;      // follow first empty row and oldest row
		logic write_row;  // write the held pair into the victim row
		logic out_load;   // move the lookup result into the output register
	} arpc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;      // current row address equals the key
		logic empty;      // current row is empty
		logic last;       // current row is the last one
		logic op_rem;     // held item is a remember
	} arpc_stat_t;

endpackage

// ----- rtl/core/arpc_if.sv -----
// Valid/ready channel interfaces for the ARP cache request and response items.
`timescale 1ns / 1ps

interface arpc_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [arpc_pkg::IP_W-1:0] ip_addr;
	logic [arpc_pkg::MAC_W-1:0] mac_in;

	modport source (output valid, output opcode, output ip_addr, output mac_in, input ready);
	modport sink (input valid, input opcode, input ip_addr, input mac_in, output ready);
endinterface

interface arpc_rsp_if;
	logic valid;
	logic ready;
	logic [arpc_pkg::MAC_W-1:0] mac_out;
	logic hit;

	modport source (output valid, output mac_out, output hit, input ready);
	modport sink (input valid, input mac_out, input hit, output ready);
endinterface

// ----- rtl/core/arp_cache_lru_table.sv -----
// Top level of the ARP cache with age-based replacement.
//
//   channel  dir  payload                      notes
//   req      in   opcode, ip_addr, mac_in      lookup or remember item
//   rsp      out  mac_out, hit                 one item per lookup only
//
// A lookup is accepted, then the scan steps through the rows up to the first
// match or the last row, then the result is loaded into the output register.
// A remember ages every row in its accept cycle, then scans up to the first
// empty row or the last row and writes the held pair into the victim row. The
// row scan takes one row per cycle through a single compare.
// Reset clears all rows at once. A new item is accepted while a result waits;
// a finished lookup holds until the output register is free.
`timescale 1ns / 1ps

module arp_cache_lru_table (
	input  logic           clk,
	input  logic           arst_n,
	arpc_req_if.sink       req,
	arpc_rsp_if.source     rsp
);

	arpc_pkg::arpc_cmd_t  cmd;
	arpc_pkg::arpc_stat_t stat;

	// Sequencer.
	arpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.req_opcode (req.opcode),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Row storage and result.
	arpc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.opcode  (req.opcode),
		.ip_addr (req.ip_addr),
		.mac_in  (req.mac_in),
		.mac_out (rsp.mac_out),
		.hit     (rsp.hit)
	);

endmodule

// ----- rtl/core/arpc_dp.sv -----
// Datapath of the ARP cache: row storage, scan index, victim tracking and result register.
`timescale 1ns / 1ps

module arpc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  arpc_pkg::arpc_cmd_t           cmd,
	output arpc_pkg::arpc_stat_t          stat,
	input  logic                          opcode,
	input  logic [arpc_pkg::IP_W-1:0]     ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0]    mac_in,
	output logic [arpc_pkg::MAC_W-1:0]    mac_out,
	output logic                          hit
);

	logic [arpc_pkg::IP_W-1:0]  row_addr_q [arpc_pkg::ENTRIES];
	logic [arpc_pkg::MAC_W-1:0] row_mac_q  [arpc_pkg::ENTRIES];
	logic [arpc_pkg::AGE_W-1:0] row_age_q  [arpc_pkg::ENTRIES];

	logic                        op_q;
	logic [arpc_pkg::IP_W-1:0]   key_q;
	logic [arpc_pkg::MAC_W-1:0]  mac_q;
	logic [arpc_pkg::IDX_W-1:0]  idx_q;
	logic [arpc_pkg::IDX_W-1:0]  victim_q;
	logic [arpc_pkg::AGE_W-1:0]  oldest_q;
	logic                        found_q;
	logic [arpc_pkg::MAC_W-1:0]  out_mac_q;
	logic                        out_hit_q;

	logic [arpc_pkg::IP_W-1:0]   cur_addr;
	logic [arpc_pkg::AGE_W-1:0]  cur_age;

	// Read the row under the scan index.
	assign cur_addr = row_addr_q[idx_q];
	assign cur_age = row_age_q[idx_q];

	assign stat.match = (cur_addr == key_q);
	assign stat.empty = (cur_addr == arpc_pkg::EMPTY_ADDR);
	assign stat.last = (idx_q == arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1));
	assign stat.op_rem = (op_q == arpc_pkg::OP_REMEMBER);

	assign mac_out = out_mac_q;
	assign hit = out_hit_q;

	// Scan index, victim search and lookup hit flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			victim_q <= '0;
			oldest_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				victim_q <= '0;
				oldest_q <= '0;
				found_q <= 1'b0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + arpc_pkg::IDX_W'(1);
			end
			if (cmd.track) begin
				if (stat.empty) begin
					victim_q <= idx_q;
				end else if (cur_age > oldest_q) begin
					oldest_q <= cur_age;
					victim_q <= idx_q;
				end
			end
			if (cmd.lk_hit) begin
				found_q <= 1'b1;
			end
		end
	end

	// Item payload and output payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			key_q <= ip_addr;
			mac_q <= mac_in;
		end
		if (cmd.out_load) begin
			out_mac_q <= found_q ? row_mac_q[idx_q] : arpc_pkg::BCAST_MAC;
			out_hit_q <= found_q;
		end
	end

	// Row storage: aging, hit refresh and replacement write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < arpc_pkg::ENTRIES; r++) begin
				row_addr_q[r] <= '0;
				row_mac_q[r] <= '0;
				row_age_q[r] <= '0;
			end
		end else begin
			if (cmd.age_all) begin
				for (int r = 0; r < arpc_pkg::ENTRIES; r++) begin
					if (row_age_q[r] != arpc_pkg::AGE_MAX) begin
						row_age_q[r] <= row_age_q[r] + arpc_pkg::AGE_W'(1);
					end
				end
			end
			if (cmd.lk_hit) begin
				row_age_q[idx_q] <= '0;
			end
			if (cmd.write_row) begin
				row_addr_q[victim_q] <= key_q;
				row_mac_q[victim_q] <= mac_q;
				row_age_q[victim_q] <= '0;
			end
		end
	end

endmodule

// ----- rtl/core/arpc_ctrl.sv -----
// Controller of the ARP cache: sequences the scan and owns both channel handshakes.
`timescale 1ns / 1ps

module arpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  logic                 req_opcode,
	input  arpc_pkg::arpc_stat_t stat,
	output arpc_pkg::arpc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   req_take;
	logic   rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_take = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// Commands decoded from the current state and datapath status.
	// A remember ages every row in the cycle that accepts it.
	always_comb begin
		cmd = '0;
		cmd.load = req_take;
		cmd.age_all = req_take && (req_opcode == arpc_pkg::OP_REMEMBER);
		case (state_q)
			ST_SCAN: begin
				if (stat.op_rem) begin
					cmd.track = 1'b1;
					cmd.idx_inc = !stat.empty && !stat.last;
				end else begin
					cmd.lk_hit = stat.match;
					cmd.idx_inc = !stat.match && !stat.last;
				end
			end
			ST_WRITE: begin
				cmd.write_row = 1'b1;
			end
			ST_RESP: begin
				cmd.out_load = rsp_free;
			end
			default: begin
			end
		endcase
	end

	// State sequence and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.op_rem) begin
						if (stat.empty || stat.last) begin
							state_q <= ST_WRITE;
						end
					end else if (stat.match || stat.last) begin
						state_q <= ST_RESP;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_RESP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
